### hw/rtl/drfd_pkg.sv
package drfd_pkg;

   localparam int BYTE_W          = 8;
   localparam int DATA_W          = 16;
   localparam int ADDR_IN_W       = 15;
   localparam int PTR_W           = 17;
   localparam int FRAME_WORDS_DEF = 32000;
   localparam int QUEUE_DEPTH     = 4;

   // stream opcodes
   localparam logic [BYTE_W-1:0] OP_END       = 8'h00;
   localparam logic [BYTE_W-1:0] OP_END_ALT   = 8'h13;
   localparam logic [BYTE_W-1:0] OP_SKIP_ONE  = 8'h02;
   localparam logic [BYTE_W-1:0] OP_SKIP_N    = 8'h03;
   localparam logic [BYTE_W-1:0] OP_SKIP_W    = 8'h04;
   localparam logic [BYTE_W-1:0] OP_LIT_FIRST = 8'h06;
   localparam logic [BYTE_W-1:0] OP_LIT_LAST  = 8'h0a;
   localparam logic [BYTE_W-1:0] OP_LIT_N     = 8'h0b;
   localparam logic [BYTE_W-1:0] OP_LIT_W     = 8'h0c;
   localparam logic [BYTE_W-1:0] OP_REP_FIRST = 8'h0d;
   localparam logic [BYTE_W-1:0] OP_REP_LAST  = 8'h10;
   localparam logic [BYTE_W-1:0] OP_REP_N     = 8'h11;
   localparam logic [BYTE_W-1:0] OP_REP_W     = 8'h12;

   // short literal and repeat opcodes carry their count as an offset
   localparam logic [BYTE_W-1:0] LIT_BIAS = 8'h05;
   localparam logic [BYTE_W-1:0] REP_BIAS = 8'h0b;

   // transaction code on the item input
   localparam logic CMD_SOURCE = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   typedef enum logic [2:0] {
      K_NONE,
      K_END,
      K_SKIP,
      K_PUT,
      K_REPEAT,
      K_READ
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [DATA_W-1:0]      word;
      logic [PTR_W-1:0]       count;
      logic [ADDR_IN_W-1:0]   addr;
   } work_type;

endpackage

### hw/rtl/drfd_if.sv
interface drfd_req_if import drfd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   cmd;
   logic [BYTE_W-1:0]      src_byte;
   logic [ADDR_IN_W-1:0]   read_addr;

   modport source (output valid, output cmd, output src_byte, output read_addr, input ready);
   modport sink   (input valid, input cmd, input src_byte, input read_addr, output ready);
endinterface

interface drfd_rsp_if import drfd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   word_data;
   logic                frame_end;
   logic                overflow;

   modport source (output valid, output word_data, output frame_end, output overflow, input ready);
   modport sink   (input valid, input word_data, input frame_end, input overflow, output ready);
endinterface

### hw/rtl/drfd_ram.sv
module drfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### hw/rtl/drfd_front.sv
module drfd_front import drfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   drfd_req_if.sink      req_chan,
   input  logic          store_ready,
   input  logic          queue_full,
   output logic          push_valid,
   output work_type      push_data
);

   typedef enum logic [2:0] {
      PH_OP,
      PH_N8,
      PH_W_LO,
      PH_W_HI,
      PH_LIT_LO,
      PH_LIT_HI,
      PH_VAL_LO,
      PH_VAL_HI
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [BYTE_W-1:0]    op_ff, op_in;
   logic [PTR_W-1:0]     run_ff, run_in;
   logic [BYTE_W-1:0]    low_ff, low_in;

   logic                 accept;
   logic [BYTE_W-1:0]    b;
   logic [PTR_W-1:0]     count;
   logic [PTR_W-1:0]     run_dec;

   assign req_chan.ready = store_ready && !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push_valid     = accept;
   assign b              = req_chan.src_byte;

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      run_in   = run_ff;
      low_in   = low_ff;
      count    = '0;
      run_dec  = run_ff;

      push_data.kind  = K_NONE;
      push_data.word  = {b, low_ff};
      push_data.count = '0;
      push_data.addr  = req_chan.read_addr;

      if (req_chan.cmd == CMD_READ) begin
         // reads leave the parse alone
         push_data.kind = K_READ;
      end else begin
         unique case (phase_ff)
            PH_OP: begin
               op_in = b;
               case (b) inside
                  OP_END, OP_END_ALT: begin
                     push_data.kind = K_END;
                  end
                  OP_SKIP_ONE: begin
                     push_data.kind  = K_SKIP;
                     push_data.count = PTR_W'(1);
                  end
                  OP_SKIP_N, OP_LIT_N, OP_REP_N: begin
                     phase_in = PH_N8;
                  end
                  OP_SKIP_W, OP_LIT_W, OP_REP_W: begin
                     phase_in = PH_W_LO;
                  end
                  [OP_LIT_FIRST:OP_LIT_LAST]: begin
                     run_in   = {{(PTR_W-BYTE_W){1'b0}}, b - LIT_BIAS};
                     phase_in = PH_LIT_LO;
                  end
                  [OP_REP_FIRST:OP_REP_LAST]: begin
                     run_in   = {{(PTR_W-BYTE_W){1'b0}}, b - REP_BIAS};
                     phase_in = PH_VAL_LO;
                  end
                  default: begin
                     push_data.kind = K_NONE;
                  end
               endcase
            end
            PH_N8, PH_W_HI: begin
               if (phase_ff == PH_N8) begin
                  count = {{(PTR_W-BYTE_W){1'b0}}, b} + PTR_W'(1);
               end else begin
                  count = {{(PTR_W-2*BYTE_W){1'b0}}, b, low_ff} + PTR_W'(1);
               end
               case (op_ff) inside
                  OP_SKIP_N, OP_SKIP_W: begin
                     push_data.kind  = K_SKIP;
                     push_data.count = count;
                     phase_in        = PH_OP;
                  end
                  OP_LIT_N, OP_LIT_W: begin
                     run_in   = count;
                     phase_in = PH_LIT_LO;
                  end
                  default: begin
                     run_in   = count;
                     phase_in = PH_VAL_LO;
                  end
               endcase
            end
            PH_W_LO, PH_LIT_LO, PH_VAL_LO: begin
               low_in = b;
               unique case (phase_ff)
                  PH_W_LO:   phase_in = PH_W_HI;
                  PH_LIT_LO: phase_in = PH_LIT_HI;
                  default:   phase_in = PH_VAL_HI;
               endcase
            end
            PH_LIT_HI: begin
               push_data.kind = K_PUT;
               if (run_ff != '0) begin
                  run_dec = run_ff - PTR_W'(1);
               end
               run_in   = run_dec;
               phase_in = (run_dec != '0) ? PH_LIT_LO : PH_OP;
            end
            PH_VAL_HI: begin
               push_data.kind  = K_REPEAT;
               push_data.count = run_ff;
               run_in          = '0;
               phase_in        = PH_OP;
            end
            default: begin
               phase_in = PH_OP;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OP;
         op_ff    <= '0;
         run_ff   <= '0;
         low_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         run_ff   <= run_in;
         low_ff   <= low_in;
      end
   end

endmodule

### hw/rtl/drfd_queue.sv
module drfd_queue import drfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  work_type   push_data,
   output logic       full,
   input  logic       pop,
   output logic       not_empty,
   output work_type   head
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   work_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic            do_push, do_pop;

   assign full      = (fill_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/drfd_back.sv
module drfd_back import drfd_pkg::*; #(
   parameter int FRAME_WORDS = FRAME_WORDS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          not_empty,
   input  work_type      head,
   output logic          pop,
   output logic          store_ready,
   drfd_rsp_if.source    rsp_chan
);

   localparam int AW = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
   localparam logic [PTR_W-1:0] FW_P   = PTR_W'(FRAME_WORDS);
   localparam logic [PTR_W-1:0] FW_END = PTR_W'(FRAME_WORDS - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_REPEAT
   } state_type;

   state_type            state_ff, state_in;
   logic [PTR_W-1:0]     wp_ff, wp_in;
   logic                 flag_ff, flag_in;
   logic [DATA_W-1:0]    rep_word_ff, rep_word_in;
   logic [PTR_W-1:0]     rep_cnt_ff, rep_cnt_in;
   logic                 oob_ff, oob_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_word_ff, rsp_word_in;
   logic                 rsp_end_ff, rsp_end_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic                 wr_en, rd_en;
   logic [DATA_W-1:0]    wr_data, rd_data;
   logic [PTR_W-1:0]     rd_addr_ext;
   logic                 can_emit;
   logic                 room;
   logic [PTR_W:0]       skip_sum;

   drfd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (FRAME_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ext[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rd_addr_ext        = {{(PTR_W-ADDR_IN_W){1'b0}}, head.addr};
   assign can_emit           = !rsp_valid_ff || rsp_chan.ready;
   assign room               = (wp_ff < FW_P);
   assign skip_sum           = {1'b0, wp_ff} + {1'b0, head.count};
   assign store_ready        = (state_ff != ST_CLEAR);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.word_data = rsp_word_ff;
   assign rsp_chan.frame_end = rsp_end_ff;
   assign rsp_chan.overflow  = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      flag_in      = flag_ff;
      rep_word_in  = rep_word_ff;
      rep_cnt_in   = rep_cnt_ff;
      oob_in       = oob_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in  = rsp_word_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_data      = '0;
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // write pointer doubles as the sweep address while zeroing the store
            wr_en = 1'b1;
            if (wp_ff == FW_END) begin
               wp_in    = '0;
               state_in = ST_IDLE;
            end else begin
               wp_in = wp_ff + PTR_W'(1);
            end
         end
         ST_IDLE: begin
            if (not_empty) begin
               unique case (head.kind)
                  K_READ: begin
                     pop      = 1'b1;
                     rd_en    = 1'b1;
                     oob_in   = (rd_addr_ext >= FW_P);
                     state_in = ST_READ;
                  end
                  K_REPEAT: begin
                     pop         = 1'b1;
                     rep_word_in = head.word;
                     rep_cnt_in  = head.count;
                     state_in    = ST_REPEAT;
                  end
                  K_NONE, K_END, K_SKIP, K_PUT: begin
                     if (can_emit) begin
                        pop          = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_word_in  = '0;
                        rsp_end_in   = 1'b0;
                        rsp_ovf_in   = flag_ff;
                        case (head.kind)
                           K_END: begin
                              rsp_end_in = 1'b1;
                              wp_in      = '0;
                              flag_in    = 1'b0;
                           end
                           K_SKIP: begin
                              wp_in = (skip_sum > {1'b0, FW_P}) ? FW_P : skip_sum[PTR_W-1:0];
                           end
                           K_PUT: begin
                              if (room) begin
                                 wr_en   = 1'b1;
                                 wr_data = head.word;
                                 wp_in   = wp_ff + PTR_W'(1);
                              end else begin
                                 flag_in    = 1'b1;
                                 rsp_ovf_in = 1'b1;
                              end
                           end
                           default: begin
                              rsp_end_in = 1'b0;
                           end
                        endcase
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = oob_ff ? '0 : rd_data;
               rsp_end_in   = 1'b0;
               rsp_ovf_in   = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_REPEAT: begin
            if (rep_cnt_ff != '0 && room) begin
               wr_en      = 1'b1;
               wr_data    = rep_word_ff;
               wp_in      = wp_ff + PTR_W'(1);
               rep_cnt_in = rep_cnt_ff - PTR_W'(1);
            end else if (can_emit) begin
               // words left over once the frame is full count as dropped
               flag_in      = flag_ff || (rep_cnt_ff != '0);
               rsp_valid_in = 1'b1;
               rsp_word_in  = '0;
               rsp_end_in   = 1'b0;
               rsp_ovf_in   = flag_ff || (rep_cnt_ff != '0);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wp_ff        <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rep_word_ff <= rep_word_in;
      rep_cnt_ff  <= rep_cnt_in;
      oob_ff      <= oob_in;
      rsp_word_ff <= rsp_word_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

endmodule

### hw/rtl/delta_rle_frame_decoder.sv
// channel    | dir | handshake     | payload
// req_chan   | in  | valid / ready | cmd, src_byte, read_addr
// rsp_chan   | out | valid / ready | word_data, frame_end, overflow
//
// after reset the frame store is zeroed, one word a cycle, with req_chan.ready low
// throughout.
// the parser takes one transaction a cycle while its four-entry queue has room.
// executor: a source byte is executed in ST_IDLE, a read passes through ST_READ (registered store read),
// a repeat writes its words in ST_REPEAT until done or the frame is full, one write a cycle.
// either side may stall; the result register holds until rsp_chan.ready.
module delta_rle_frame_decoder import drfd_pkg::*; #(
   parameter int FRAME_WORDS = FRAME_WORDS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   drfd_req_if.sink      req_chan,
   drfd_rsp_if.source    rsp_chan
);

   logic       store_ready;
   logic       queue_full;
   logic       push_valid;
   work_type   push_data;
   logic       pop;
   logic       not_empty;
   work_type   head;

   drfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .store_ready (store_ready),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   drfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   drfd_back #(
      .FRAME_WORDS (FRAME_WORDS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .not_empty   (not_empty),
      .head        (head),
      .pop         (pop),
      .store_ready (store_ready),
      .rsp_chan    (rsp_chan)
   );

endmodule
